// ===== rtl/fird_pkg.sv =====
package fird_pkg;

    // field widths
    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 18;
    localparam int IDX_W    = 7;
    localparam int DECIM_W  = 7;
    localparam int PHASE_W  = 6;
    localparam int PROD_W   = SAMPLE_W + COEF_W;

    // decimation limits
    localparam int DECIM_MAX = 64;

    // rounding of the sum of q3.31 products down to q1.15
    localparam int FRAC_SHIFT = 16;
    localparam int ROUND_HALF = 32768;
    localparam int OUT_MAX    = 32767;
    localparam int OUT_MIN_MAG = 32768;

    // item kinds carried in tuser
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_COEF   = 1'b1;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [COEF_W-1:0]   coef_t;

    // controls broadcast along the cell chain
    typedef struct packed {
        logic shift;   // take a new sample, oldest drops out of cell 0
        logic rotate;  // circulate sample and coefficient one cell toward cell 0
    } fird_ctl_t;

endpackage

// ===== rtl/fird_cell.sv =====
module fird_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  fird_pkg::fird_ctl_t ctl,
    input  logic               coef_we,
    input  fird_pkg::coef_t    coef_wdata,
    input  fird_pkg::sample_t  sample_in,
    input  fird_pkg::coef_t    coef_in,
    output fird_pkg::sample_t  sample_out,
    output fird_pkg::coef_t    coef_out
);
    import fird_pkg::*;

    sample_t sample_reg;
    coef_t   coef_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_reg <= '0;
            coef_reg   <= '0;
        end else begin
            if (ctl.shift || ctl.rotate) begin
                sample_reg <= sample_in;
            end
            if (ctl.rotate) begin
                coef_reg <= coef_in;
            end else if (coef_we) begin
                coef_reg <= coef_wdata;
            end
        end
    end

    assign sample_out = sample_reg;
    assign coef_out   = coef_reg;

endmodule

// ===== rtl/fird_mac.sv =====
module fird_mac #(
    parameter int ACC_W = 42
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              clr,
    input  logic              mul_en,
    input  fird_pkg::sample_t sample,
    input  fird_pkg::coef_t   coef,
    output logic signed [fird_pkg::SAMPLE_W-1:0] result
);
    import fird_pkg::*;

    localparam logic signed [ACC_W-1:0] Q_MAX = ACC_W'(OUT_MAX);
    localparam logic signed [ACC_W-1:0] Q_MIN = -(ACC_W'(OUT_MIN_MAG));

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic                     prod_vld_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  rnd;
    logic signed [ACC_W-1:0]  quo;

    always_comb begin
        logic signed [PROD_W-1:0] a_ext;
        logic signed [PROD_W-1:0] b_ext;
        a_ext = PROD_W'(sample);
        b_ext = PROD_W'(coef);
        prod_next = a_ext * b_ext;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_vld_reg <= 1'b0;
        end else begin
            prod_vld_reg <= mul_en;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        if (clr) begin
            acc_reg <= '0;
        end else if (prod_vld_reg) begin
            acc_reg <= acc_reg + {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        end
    end

    // round half up, floor shift, clamp to q1.15
    assign rnd = acc_reg + ACC_W'(ROUND_HALF);
    assign quo = rnd >>> FRAC_SHIFT;

    always_comb begin
        if (quo > Q_MAX) begin
            result = SAMPLE_W'(OUT_MAX);
        end else if (quo < Q_MIN) begin
            result = Q_MIN[SAMPLE_W-1:0];
        end else begin
            result = quo[SAMPLE_W-1:0];
        end
    end

endmodule

// ===== rtl/fir_decimator.sv =====
// decimating fir filter for a stream of q1.15 samples
//
// input channel (s_*): one transaction is either a sample (s_tuser = 0) or a
// coefficient write (s_tuser = 1). a coefficient write stores one q2.16 tap;
// an index at or above TAPS is dropped.
// output channel (m_*): one q1.15 result per transaction.
// cfg_wr_en/cfg_wr_data set the decimation factor (0 acts as 1, above 64 as 64);
// write it only while the filter is idle.
//
// a sample that produces no result does not stall the input. the first result comes once
// TAPS samples have been taken, then one every decimation-factor samples. such a
// sample starts a sweep: the cells rotate their sample/coefficient pairs past a
// single multiply-accumulate unit, one tap per cycle. the result lands in the
// output register after the run, flush and finish steps, and s_tready is low
// until then, so a new sample is taken only once the sweep has ended.
// the output register parts the two sides: while a result waits for m_tready the
// filter still takes new transactions; a new result waits in the finish step
// (s_tready low) until the register is free.
// reset (aresetn low, synchronous) zeroes the delay line, coefficients and
// counters, and sets the decimation factor to 1.
module fir_decimator #(
    parameter int TAPS = 127
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration: decimation factor
    input  logic        cfg_wr_en,
    input  logic [6:0]  cfg_wr_data,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // sample_in[15:0], coef_index[22:16], coef_value[40:23], zero
    input  logic        s_tuser,   // op
    // output channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // sample_out[15:0]
);
    import fird_pkg::*;

    localparam int CNT_W  = $clog2(TAPS);
    localparam int FILL_W = $clog2(TAPS + 1);
    localparam int ACC_W  = PROD_W + $clog2(TAPS) + 1;

    // sequencer states
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_RUN    = 2'd1;
    localparam logic [1:0] ST_FLUSH  = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    // unpacked input fields
    sample_t          s_sample;
    logic [IDX_W-1:0] s_coef_index;
    coef_t            s_coef_value;

    assign s_sample     = s_tdata[15:0];
    assign s_coef_index = s_tdata[22:16];
    assign s_coef_value = s_tdata[40:23];

    logic [1:0]         state_reg, state_next;
    logic [CNT_W-1:0]   rot_cnt_reg, rot_cnt_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [DECIM_W-1:0] decim_reg;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [SAMPLE_W-1:0] out_reg;

    logic               s_acc;
    logic               smp_acc;
    logic               coef_acc;
    logic               start;
    logic               out_free;
    logic [DECIM_W-1:0] eff_decim;
    logic [DECIM_W-1:0] phase_inc;
    fird_ctl_t          ctl;
    logic signed [SAMPLE_W-1:0] mac_result;

    // cell chain taps
    sample_t cell_sample [TAPS];
    coef_t   cell_coef   [TAPS];

    assign s_tready = aresetn && (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign smp_acc  = s_acc && (s_tuser == OP_SAMPLE);
    assign coef_acc = s_acc && (s_tuser == OP_COEF);
    assign out_free = !m_tvalid_reg || m_tready;

    // clamp the programmed factor into 1..64
    always_comb begin
        if (decim_reg == '0) begin
            eff_decim = DECIM_W'(1);
        end else if (decim_reg > DECIM_W'(DECIM_MAX)) begin
            eff_decim = DECIM_W'(DECIM_MAX);
        end else begin
            eff_decim = decim_reg;
        end
    end

    assign phase_inc = {1'b0, phase_reg} + DECIM_W'(1);

    // fill and phase tracking decide which samples start a sweep
    always_comb begin
        fill_next  = fill_reg;
        phase_next = phase_reg;
        start      = 1'b0;
        if (smp_acc) begin
            if (fill_reg < FILL_W'(TAPS)) begin
                fill_next = fill_reg + FILL_W'(1);
                if (fill_reg == FILL_W'(TAPS - 1)) begin
                    start      = 1'b1;
                    phase_next = '0;
                end
            end else if (phase_inc >= eff_decim) begin
                start      = 1'b1;
                phase_next = '0;
            end else begin
                phase_next = phase_inc[PHASE_W-1:0];
            end
        end
    end

    // sweep sequencer
    always_comb begin
        state_next    = state_reg;
        rot_cnt_next  = rot_cnt_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        ctl.shift     = smp_acc;
        ctl.rotate    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    state_next   = ST_RUN;
                    rot_cnt_next = '0;
                end
            end
            ST_RUN: begin
                // cell 0 feeds the multiplier, everything moves one cell down
                ctl.rotate   = 1'b1;
                rot_cnt_next = rot_cnt_reg + CNT_W'(1);
                if (rot_cnt_reg == CNT_W'(TAPS - 1)) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                // last product lands in the accumulator
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            rot_cnt_reg  <= '0;
            fill_reg     <= '0;
            phase_reg    <= '0;
            decim_reg    <= DECIM_W'(1);
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rot_cnt_reg  <= rot_cnt_next;
            fill_reg     <= fill_next;
            phase_reg    <= phase_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en) begin
                decim_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_FINISH && out_free) begin
            out_reg <= mac_result;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_reg;

    // row of cells: cell 0 holds the oldest sample and tap 0
    for (genvar k = 0; k < TAPS; k++) begin : g_cell
        sample_t right_sample;
        coef_t   right_coef;
        logic    we;

        if (k == TAPS - 1) begin : g_last
            // newest sample enters here; during a sweep cell 0 wraps around
            assign right_sample = ctl.rotate ? cell_sample[0] : s_sample;
            assign right_coef   = cell_coef[0];
        end else begin : g_mid
            assign right_sample = cell_sample[k+1];
            assign right_coef   = cell_coef[k+1];
        end

        assign we = coef_acc && (32'(s_coef_index) == 32'(k));

        fird_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctl        (ctl),
            .coef_we    (we),
            .coef_wdata (s_coef_value),
            .sample_in  (right_sample),
            .coef_in    (right_coef),
            .sample_out (cell_sample[k]),
            .coef_out   (cell_coef[k])
        );
    end

    fird_mac #(
        .ACC_W (ACC_W)
    ) u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clr     (start),
        .mul_en  (ctl.rotate),
        .sample  (cell_sample[0]),
        .coef    (cell_coef[0]),
        .result  (mac_result)
    );

`ifndef SYNTHESIS
    // a sweep is exactly TAPS rotations long
    a_sweep_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN && rot_cnt_reg == CNT_W'(TAPS - 1)) |=> (state_reg == ST_FLUSH))
        else $error("sweep did not end after TAPS rotations");

    // the fill count saturates at the line length
    a_fill_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_W'(TAPS))
        else $error("fill count beyond line length");

    // phase never reaches the largest decimation factor
    a_phase_rng: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, phase_reg} < DECIM_W'(DECIM_MAX))
        else $error("phase count out of range");

    // a finished sweep with a free output register always presents a result
    a_finish_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH && out_free) |=> (m_tvalid_reg && state_reg == ST_IDLE))
        else $error("finished result not presented");

    // a sweep only starts on an accepted sample
    a_start_smp: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && state_next == ST_RUN) |-> smp_acc)
        else $error("sweep started without a sample");
`endif

endmodule
